// ----- sv/akc_pkg.sv -----
// Shared types and constants for the autokey cipher stream block.
package akc_pkg;

    localparam int LEN_W    = 6;   // key length, letter count and ring pointer width
    localparam int LET_W    = 5;   // letter index width
    localparam int CHAR_W   = 8;
    localparam int CFG_W    = 60;  // widest configuration register
    localparam int CFG_IDX_W = 3;
    localparam int KEY_REGS = 4;
    localparam int KEY_SLOTS = 48; // key letters held by the key registers

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;
    localparam logic [LET_W-1:0]  ALPHA  = 5'd26;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LENGTH = 3'd0,
        REG_DECRYPT    = 3'd1,
        REG_KEYS_0     = 3'd2,
        REG_KEYS_1     = 3'd3,
        REG_KEYS_2     = 3'd4,
        REG_KEYS_3     = 3'd5
    } cfg_reg_t;

    // Settings seen by the datapath.
    typedef struct packed {
        logic [LEN_W-1:0] n;        // effective key length
        logic             decrypt;
        logic             key_bad;  // a key letter in use is above 25
    } akc_cfg_t;

endpackage

// ----- sv/akc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module akc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 48,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/akc_keystore.sv -----
// Configuration registers, effective key length, key check and key letter lookup.
module akc_keystore #(
    parameter int KEY_MAX = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [akc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [akc_pkg::CFG_W-1:0]     cfg_data,
    input  logic [akc_pkg::LEN_W-1:0]     key_idx,
    output logic [akc_pkg::LET_W-1:0]     key_letter,
    output akc_pkg::akc_cfg_t             cfg
);
    import akc_pkg::*;

    logic [LEN_W-1:0]                 key_length_reg;
    logic                             decrypt_reg;
    logic [KEY_REGS-1:0][CFG_W-1:0]   keys_reg;
    logic [KEY_REGS*CFG_W-1:0]        key_flat;
    logic [LEN_W-1:0]                 n;
    logic                             bad;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= LEN_W'(1);
            decrypt_reg    <= 1'b0;
            keys_reg       <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_LENGTH: key_length_reg <= cfg_data[LEN_W-1:0];
                REG_DECRYPT:    decrypt_reg    <= cfg_data[0];
                REG_KEYS_0:     keys_reg[0]    <= cfg_data;
                REG_KEYS_1:     keys_reg[1]    <= cfg_data;
                REG_KEYS_2:     keys_reg[2]    <= cfg_data;
                REG_KEYS_3:     keys_reg[3]    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign key_flat = keys_reg;

    // Zero acts as one, anything past KEY_MAX clamps.
    always_comb begin
        if (key_length_reg == '0) begin
            n = LEN_W'(1);
        end else if (key_length_reg > LEN_W'(KEY_MAX)) begin
            n = LEN_W'(KEY_MAX);
        end else begin
            n = key_length_reg;
        end
    end

    always_comb begin
        bad = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if ((LEN_W'(j) < n) && (key_flat[j*LET_W +: LET_W] >= ALPHA)) begin
                bad = 1'b1;
            end
        end
    end

    always_comb begin
        key_letter = '0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (key_idx == LEN_W'(j)) begin
                key_letter = key_flat[j*LET_W +: LET_W];
            end
        end
    end

    assign cfg.n       = n;
    assign cfg.decrypt = decrypt_reg;
    assign cfg.key_bad = bad;

endmodule

// ----- sv/akc_mod26.sv -----
// Key choice and mod-26 add or subtract of one letter.
module akc_mod26 (
    input  logic [akc_pkg::LET_W-1:0] p,
    input  logic [akc_pkg::LET_W-1:0] key_letter,
    input  logic [akc_pkg::LET_W-1:0] hist,
    input  logic                      use_key,
    input  logic                      decrypt,
    output logic [akc_pkg::LET_W-1:0] r
);
    import akc_pkg::*;

    logic [LET_W-1:0] hist_mod;
    logic [LET_W-1:0] k;
    logic [LET_W:0]   sum;
    logic [LET_W:0]   diff;

    always_comb begin
        hist_mod = (hist >= ALPHA) ? LET_W'(hist - ALPHA) : hist;
        k        = use_key ? key_letter : hist_mod;
        sum      = {1'b0, p} + {1'b0, k};
        diff     = {1'b0, p} - {1'b0, k};
        if (decrypt) begin
            r = diff[LET_W] ? LET_W'(diff + {1'b0, ALPHA}) : diff[LET_W-1:0];
        end else begin
            r = (sum >= {1'b0, ALPHA}) ? LET_W'(sum - {1'b0, ALPHA}) : sum[LET_W-1:0];
        end
    end

endmodule

// ----- sv/autokey_cipher_stream_top.sv -----
// Top level of the plaintext autokey cipher stream block.
//
// Usage:
//   Input channel s_*: one byte per item (s_text_char) with s_message_start,
//   which restarts the keystream before that byte. Output channel m_*: one
//   result item per input item, in order (m_result_char, m_key_invalid).
//   Uppercase A-Z is enciphered (C = P + K mod 26) or deciphered (P = C - K
//   mod 26); other bytes pass through. The first key_length letters of a
//   message use the configured key, later ones the plaintext letter
//   key_length letters back, held in a 48 x 5 ring RAM.
//   Configuration (cfg_we / cfg_index / cfg_data) is written while idle.
// Timing:
//   An accepted item is registered in the second stage, then in the output
//   register behind m_valid. One item per cycle while m_ready is high: ring
//   read is issued at acceptance, the mod-26 step and ring write happen in
//   the second stage, and a back-to-back hit on the slot being written is forwarded.
// Reset: pipeline empty, key_length 1, encipher, key letters 0, count and
//   pointer 0. s_ready is low during reset. The ring needs no clearing.
// Stall: when m_ready is low the output register holds; one more item can
//   sit in the second stage, then s_ready drops.
module autokey_cipher_stream_top #(
    parameter int KEY_MAX = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [akc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [akc_pkg::CFG_W-1:0]     cfg_data,
    // input item
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_text_char,
    input  logic                          s_message_start,
    // result item
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_result_char,
    output logic                          m_key_invalid
);
    import akc_pkg::*;

    localparam int RING_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    akc_cfg_t          cfg;
    logic [LET_W-1:0]  key_letter;

    // keystream state
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  ptr_reg, ptr_next;

    // accept-side decode
    logic              accept;
    logic [LEN_W-1:0]  cnt0, ptr_raw0, ptr0, ptr_inc;
    logic              is_letter, use_key0;

    // second stage
    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_bad_reg, s1_letter_reg, s1_use_key_reg, s1_decrypt_reg;
    logic [LET_W-1:0]  s1_key_reg;
    logic [LEN_W-1:0]  s1_addr_reg;
    logic              fwd_hit_reg;
    logic [LET_W-1:0]  fwd_data_reg;
    logic              s1_advance;
    logic [LET_W-1:0]  ram_rdata, hist, s1_p, s1_r, s1_plain;
    logic              ring_we;

    // output register
    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_char_reg;
    logic              m_inv_reg;

    akc_keystore #(.KEY_MAX(KEY_MAX)) u_keys (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .key_idx    (cnt0),
        .key_letter (key_letter),
        .cfg        (cfg)
    );

    // ---------------- accept side ----------------
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = aresetn && (!s1_valid_reg || s1_advance);
    assign accept     = s_valid && s_ready;

    always_comb begin
        cnt0      = s_message_start ? '0 : cnt_reg;
        ptr_raw0  = s_message_start ? '0 : ptr_reg;
        // pointer past a shrunken key length restarts at slot 0
        ptr0      = (ptr_raw0 >= cfg.n) ? '0 : ptr_raw0;
        ptr_inc   = (LEN_W'(ptr0 + LEN_W'(1)) >= cfg.n) ? '0 : LEN_W'(ptr0 + LEN_W'(1));
        is_letter = (s_text_char >= CHAR_A) && (s_text_char <= CHAR_Z);
        use_key0  = cnt0 < cfg.n;

        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (accept) begin
            if (is_letter && !cfg.key_bad) begin
                cnt_next = use_key0 ? LEN_W'(cnt0 + LEN_W'(1)) : cnt0;
                ptr_next = ptr_inc;
            end else begin
                cnt_next = cnt0;
                ptr_next = ptr_raw0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    // ring: read at acceptance, written when the second stage retires a letter under a good key
    akc_ram #(.WIDTH(LET_W), .DEPTH(KEY_MAX), .AW(RING_AW)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (s1_addr_reg[RING_AW-1:0]),
        .wdata (s1_plain),
        .re    (accept),
        .raddr (ptr0[RING_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_char_reg    <= s_text_char;
            s1_bad_reg     <= cfg.key_bad;
            s1_letter_reg  <= is_letter;
            s1_use_key_reg <= use_key0;
            s1_key_reg     <= key_letter;
            s1_decrypt_reg <= cfg.decrypt;
            s1_addr_reg    <= ptr0;
            // same slot being written this edge: RAM gives the old value
            fwd_hit_reg    <= ring_we && (s1_addr_reg == ptr0);
            fwd_data_reg   <= s1_plain;
        end
    end

    // ---------------- second stage ----------------
    assign hist  = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign s1_p  = LET_W'(s1_char_reg - CHAR_A);

    akc_mod26 u_mod26 (
        .p          (s1_p),
        .key_letter (s1_key_reg),
        .hist       (hist),
        .use_key    (s1_use_key_reg),
        .decrypt    (s1_decrypt_reg),
        .r          (s1_r)
    );

    assign s1_plain = s1_decrypt_reg ? s1_r : s1_p;
    assign ring_we  = s1_advance && s1_letter_reg && !s1_bad_reg;

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            if (s1_bad_reg) begin
                m_char_reg <= '0;
            end else if (s1_letter_reg) begin
                m_char_reg <= CHAR_A + CHAR_W'(s1_r);
            end else begin
                m_char_reg <= s1_char_reg;
            end
            m_inv_reg <= s1_bad_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_char = m_char_reg;
    assign m_key_invalid = m_inv_reg;

    // ---------------- assertions ----------------
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_key_invalid |-> m_result_char == '0)
        else $error("invalid key result carries a nonzero byte");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted item lost before second stage");

    a_ptr_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_we |-> s1_addr_reg < LEN_W'(KEY_MAX))
        else $error("ring write beyond ring depth");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LEN_W'(KEY_MAX))
        else $error("letter count beyond key maximum");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_ready |=> s1_valid_reg && m_valid_reg)
        else $error("stalled item dropped");

endmodule

// ----- tb/autokey_cipher_stream_checker.sv -----
// Checker for the autokey cipher stream: predicts every result item and compares it.
`timescale 1ns / 1ps

module autokey_cipher_stream_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [akc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [akc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_text_char,
    input  logic                          s_message_start,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [7:0]                    m_result_char,
    input  logic                          m_key_invalid,
    output int                            fail_count,
    output int                            pending
);
    import akc_pkg::*;

    localparam int LETTERS_PER_REG = KEY_SLOTS / KEY_REGS;

    typedef struct packed {
        logic [CHAR_W-1:0] result_char;
        logic              key_invalid;
    } cipher_result_t;

    // mirror of the block's settings and keystream state
    logic [LEN_W-1:0] key_len_reg;
    logic             decipher;
    logic [CFG_W-1:0] key_words [KEY_REGS];
    logic [LET_W-1:0] history [KEY_SLOTS];
    logic [LEN_W-1:0] letters_seen;
    logic [LEN_W-1:0] slot_ptr;

    cipher_result_t   predicted_chars [$];
    int               mismatches = 0;

    function automatic int effective_length();
        int n;
        n = int'(key_len_reg);
        if (n < 1) n = 1;
        if (n > KEY_SLOTS) n = KEY_SLOTS;
        return n;
    endfunction

    function automatic int key_letter(input int j);
        logic [CFG_W-1:0] word;
        word = key_words[j / LETTERS_PER_REG] >> ((j % LETTERS_PER_REG) * LET_W);
        return int'(word[LET_W-1:0]);
    endfunction

    function automatic bit key_usable(input int n);
        for (int j = 0; j < n; j++)
            if (key_letter(j) >= int'(ALPHA)) return 1'b0;
        return 1'b1;
    endfunction

    // One character through the cipher; updates the keystream state.
    function automatic cipher_result_t predict_char(input logic [7:0] ch,
                                                    input logic       restart);
        cipher_result_t res;
        int n, p, k, r, ptr;
        n = effective_length();
        if (restart) begin
            letters_seen = '0;
            slot_ptr     = '0;
        end
        if (!key_usable(n)) begin
            res.result_char = '0;
            res.key_invalid = 1'b1;
            return res;
        end
        res.key_invalid = 1'b0;
        if (ch < CHAR_A || ch > CHAR_Z) begin
            res.result_char = ch;
            return res;
        end
        p   = int'(ch) - int'(CHAR_A);
        ptr = int'(slot_ptr);
        if (ptr >= n) ptr = 0;
        if (int'(letters_seen) < n) k = key_letter(int'(letters_seen));
        else                        k = int'(history[ptr]) % int'(ALPHA);
        if (decipher) r = (p + int'(ALPHA) - k) % int'(ALPHA);
        else          r = (p + k) % int'(ALPHA);
        // ring keeps the plaintext-side letter
        history[ptr] = LET_W'(decipher ? r : p);
        ptr++;
        if (ptr >= n) ptr = 0;
        slot_ptr = LEN_W'(ptr);
        if (int'(letters_seen) < n) letters_seen = letters_seen + 1'b1;
        res.result_char = CHAR_A + CHAR_W'(r);
        return res;
    endfunction

    always @(posedge aclk) begin
        cipher_result_t want;
        if (!aresetn) begin
            key_len_reg  = LEN_W'(1);
            decipher     = 1'b0;
            foreach (key_words[i]) key_words[i] = '0;
            foreach (history[i]) history[i] = '0;
            letters_seen = '0;
            slot_ptr     = '0;
            predicted_chars.delete();
        end else begin
            // compare before predicting: the newest item cannot leave this cycle
            if (m_valid && m_ready) begin
                if (predicted_chars.size() == 0) begin
                    $error("result item with nothing outstanding: %s %02h %s %0b",
                           "result_char", m_result_char, "key_invalid", m_key_invalid);
                    mismatches++;
                end else begin
                    want = predicted_chars.pop_front();
                    if (m_result_char !== want.result_char) begin
                        $error("result_char: expected %02h, got %02h",
                               want.result_char, m_result_char);
                        mismatches++;
                    end
                    if (m_key_invalid !== want.key_invalid) begin
                        $error("key_invalid: expected %0b, got %0b",
                               want.key_invalid, m_key_invalid);
                        mismatches++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEY_LENGTH: key_len_reg  = cfg_data[LEN_W-1:0];
                    REG_DECRYPT:    decipher     = cfg_data[0];
                    REG_KEYS_0:     key_words[0] = cfg_data;
                    REG_KEYS_1:     key_words[1] = cfg_data;
                    REG_KEYS_2:     key_words[2] = cfg_data;
                    REG_KEYS_3:     key_words[3] = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predicted_chars.push_back(predict_char(s_text_char, s_message_start));
        end
        fail_count <= mismatches;
        pending    <= predicted_chars.size();
    end

endmodule

// ----- tb/autokey_cipher_stream_top_tb.sv -----
// Testbench top for the autokey cipher stream: stimulus, receiver, watchdog and verdict.
`timescale 1ns / 1ps

module autokey_cipher_stream_top_tb;
    import akc_pkg::*;

    localparam int ITEM_TARGET     = 1100;
    localparam int RX_HOLD_CYCLES  = 300;   // one long output stall to fill the pipe
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no item moving on either side
    localparam int DRAIN_SETTLE    = 4;     // settle margin after the last result before config
    localparam int LETTERS_PER_REG = KEY_SLOTS / KEY_REGS;
    localparam int LEN_MAX_FIELD   = 63;    // largest value the key_length field holds

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_text_char;
    logic                 s_message_start;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_result_char;
    logic                 m_key_invalid;

    int fail_count;
    int pending;

    // stimulus-side bookkeeping
    bit               hold_rx = 1'b0;   // asks the receiver for one long stall
    bit               tx_calm = 1'b0;   // sender runs without gaps
    logic [LET_W-1:0] key_plan [KEY_SLOTS];
    int               eff_len = 1;
    int               items_sent = 0;
    int               letters_sent = 0;
    int               settings_used = 0;
    int               decipher_settings = 0;
    int               bad_key_settings = 0;
    int               idle_cycles = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    autokey_cipher_stream_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_char     (s_text_char),
        .s_message_start (s_message_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_char   (m_result_char),
        .m_key_invalid   (m_key_invalid)
    );

    autokey_cipher_stream_checker cipher_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_char     (s_text_char),
        .s_message_start (s_message_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_char   (m_result_char),
        .m_key_invalid   (m_key_invalid),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // Watchdog: a hang shows up as a long run of cycles where no item moves.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else                                              idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Message text: mostly capitals, some spaces and punctuation, some raw bytes.
    function automatic logic [7:0] message_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return CHAR_A + 8'($urandom_range(0, 25));
        if (r < 90) return 8'($urandom_range(8'h20, 8'h40));
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: random stalls, calm stretches, and one long hold on request.
    initial begin
        int gap;
        int calm;
        int r;
        gap     = 0;
        calm    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
                hold_rx = 1'b0;
                m_ready <= 1'b1;
            end else if (calm > 0) begin
                calm--;
                m_ready <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 4)       calm = $urandom_range(30, 100);
                else if (r < 25) gap = pick_gap();
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Stop offering and wait until every outstanding item has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_SETTLE) @(negedge aclk);
    endtask

    // Writes every register from len, dec and key_plan while the block is idle.
    task automatic configure(input logic [LEN_W-1:0] len, input logic dec);
        logic [CFG_W-1:0] words [KEY_REGS];
        bit               bad;
        drain();
        bad     = 1'b0;
        eff_len = (len == 0) ? 1 : (len > KEY_SLOTS) ? KEY_SLOTS : int'(len);
        for (int j = 0; j < KEY_SLOTS; j++) begin
            words[j / LETTERS_PER_REG][(j % LETTERS_PER_REG) * LET_W +: LET_W] = key_plan[j];
            if (j < eff_len && key_plan[j] >= ALPHA) bad = 1'b1;
        end
        write_reg(REG_KEY_LENGTH, CFG_W'(len));
        write_reg(REG_DECRYPT,    CFG_W'(dec));
        write_reg(REG_KEYS_0,     words[0]);
        write_reg(REG_KEYS_1,     words[1]);
        write_reg(REG_KEYS_2,     words[2]);
        write_reg(REG_KEYS_3,     words[3]);
        settings_used++;
        decipher_settings += int'(dec);
        bad_key_settings  += int'(bad);
    endtask

    // Offer one item and hold it until accepted; valid stays high afterwards.
    task automatic send_item(input logic [7:0] ch, input logic restart);
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_text_char     <= ch;
        s_message_start <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (ch >= CHAR_A && ch <= CHAR_Z) letters_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    task automatic send_text(input string txt, input bit new_message);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], new_message && (i == 0));
    endtask

    initial begin
        int               phase;
        int               count;
        int               msg_left;
        int               n;
        int               r;
        logic [LEN_W-1:0] len;
        logic             start;

        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_KEY_LENGTH;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_text_char     = '0;
        s_message_start = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // Reset settings: one key letter, 'A'. Letter edges and bytes just
        // outside A..Z, plus lowercase, all pass or shift by zero.
        send_text("AZ", 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h40, 1'b0);
        send_item(8'h5B, 1'b0);
        send_item(8'h61, 1'b0);

        // Key "KEY"; unused key slots hold out-of-range letters, which must
        // not mark the key bad. Of six letters, the last three use the ring.
        foreach (key_plan[j]) key_plan[j] = 5'd31;
        key_plan[0] = 5'd10;
        key_plan[1] = 5'd4;
        key_plan[2] = 5'd24;
        configure(LEN_W'(3), 1'b0);
        send_text("HELLOZ", 1'b1);

        // Decipher with the same key; five letters leave the ring pointer at 2.
        configure(LEN_W'(3), 1'b1);
        send_text("RIJVS", 1'b1);

        // Shrink the key mid-message: pointer past the new length wraps to 0.
        configure(LEN_W'(2), 1'b1);
        send_text("QXB", 1'b0);

        // Bad letter inside the used key: zero result, flag set, even on a restart.
        key_plan[1] = 5'd31;
        configure(LEN_W'(3), 1'b0);
        send_text("A B", 1'b1);

        // --- random settings and messages ---
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            // first phases hit the length extremes: 0 acts as 1, 63 as the max
            if (phase == 0)      len = '0;
            else if (phase == 1) len = LEN_W'(KEY_SLOTS);
            else if (phase == 2) len = LEN_W'(LEN_MAX_FIELD);
            else begin
                r = $urandom_range(0, 99);
                if (r < 50)      len = LEN_W'($urandom_range(1, 4));
                else if (r < 60) len = LEN_W'($urandom_range(KEY_SLOTS - 2, KEY_SLOTS));
                else             len = LEN_W'($urandom_range(0, LEN_MAX_FIELD));
            end
            n = (len == 0) ? 1 : (len > KEY_SLOTS) ? KEY_SLOTS : int'(len);
            foreach (key_plan[j])
                key_plan[j] = (j < n) ? LET_W'($urandom_range(0, 25))
                                      : LET_W'($urandom_range(0, 31));
            if ($urandom_range(0, 7) == 0)
                key_plan[$urandom_range(0, n - 1)] = LET_W'($urandom_range(26, 31));
            configure(len, 1'($urandom_range(0, 1)));

            // one phase runs flat out against a long output stall
            if (phase == 3) begin
                hold_rx = 1'b1;
                tx_calm = 1'b1;
            end else begin
                tx_calm = ($urandom_range(0, 3) == 0);
            end

            count    = $urandom_range(40, 120);
            msg_left = 0;
            for (int i = 0; i < count; i++) begin
                // sender pause mid-phase until all results are back
                if (phase == 5 && i == count / 2) drain();
                if (msg_left == 0) begin
                    start    = 1'b1;
                    msg_left = $urandom_range(1, 3 * n + 6);
                end else begin
                    start = ($urandom_range(0, 29) == 0);
                end
                send_item(message_char(), start);
                msg_left--;
                if (!tx_calm && $urandom_range(0, 2) == 0) idle_sender(pick_gap());
            end
            phase++;
        end

        drain();
        repeat (8) @(negedge aclk);

        $display("Sent %0d items (%0d letters) under %0d key settings:",
                 items_sent, letters_sent, settings_used);
        $display("%0d deciphering, %0d with a bad key; key lengths 0 and 63, a shrink, %0d-cycle stall.",
                 decipher_settings, bad_key_settings, RX_HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
